// ----- rtl/core/nosc_pkg.sv -----
// Shared package of the natural-order string comparator.
// Holds default sizes, character codes, command codes and the queue control type.
// No dependencies.
`default_nettype none

package nosc_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int unsigned MAX_TOKENS_DEF  = 1024;
  localparam int unsigned NUMBER_BITS_DEF = 32;

  // Character handling
  localparam int unsigned    CHAR_W     = 8;
  localparam int unsigned    DIGIT_W    = 4;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Which string a byte belongs to
  typedef enum logic {
    OP_REF  = 1'b0,
    OP_CAND = 1'b1
  } op_e;

  // Top bit of a token: numbers sort before letters
  typedef enum logic {
    KIND_NUMBER = 1'b0,
    KIND_LETTER = 1'b1
  } kind_e;

  // Back end step within one queue entry
  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } phase_e;

  // Work carried by one queue entry: up to two token operations
  typedef struct packed {
    logic new_ref;   // start a new reference before anything else
    logic a_valid;   // token A present (a finished number)
    logic a_is_ref;  // token A goes into the reference store
    logic b_valid;   // token B present (letter, or number ended by last byte)
    logic b_is_ref;  // token B goes into the reference store
    logic last_op;   // candidate ends with token B: give a verdict
  } tok_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/nosc_if.sv -----
// Channel interfaces of the natural-order string comparator.
// Input channel carries string bytes, output channel carries verdicts.
// Depends on nosc_pkg.
`default_nettype none

interface nosc_in_if;
  import nosc_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, operation, char_code, last_char, input ready);
  modport sink   (input valid, operation, char_code, last_char, output ready);
endinterface

interface nosc_out_if;
  logic valid;
  logic ready;
  logic candidate_before_reference;
  logic reference_overflow;

  modport source (output valid, candidate_before_reference, reference_overflow,
                  input ready);
  modport sink   (input valid, candidate_before_reference, reference_overflow,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nosc_front.sv -----
// Front end: accepts bytes, builds number tokens and turns bytes into
// queue work for the back end. Depends on nosc_pkg and nosc_if.
`default_nettype none

module nosc_front #(
  parameter int unsigned NUMBER_BITS = nosc_pkg::NUMBER_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  nosc_in_if.sink                       in_i,
  input  wire logic                     full_i,
  output      logic                     push_o,
  output      nosc_pkg::tok_ctrl_t      ctrl_o,
  output      logic [NUMBER_BITS:0]     a_tok_o,
  output      logic [NUMBER_BITS:0]     b_tok_o
);
  import nosc_pkg::*;

  localparam int unsigned ACC_W = NUMBER_BITS + DIGIT_W;

  logic [NUMBER_BITS-1:0] pend_q, pend_d;
  logic                   prog_q, prog_d;
  logic                   closed_q, closed_d;

  logic                   accept;
  logic                   is_cand;
  logic                   is_digit;
  logic                   new_ref;
  logic                   open_close;
  logic                   base_prog;
  logic [NUMBER_BITS-1:0] acc_base;
  logic [DIGIT_W-1:0]     digit;
  logic [ACC_W-1:0]       acc;
  logic [NUMBER_BITS-1:0] acc_num;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  // Byte classification
  assign is_cand  = (in_i.operation == OP_CAND);
  assign is_digit = (in_i.char_code >= ASCII_ZERO) && (in_i.char_code <= ASCII_NINE);
  assign digit    = DIGIT_W'(in_i.char_code - ASCII_ZERO);

  // A reference byte after a closed reference starts over; a candidate byte
  // while the reference is open closes it first
  assign new_ref    = !is_cand && closed_q;
  assign open_close = is_cand && !closed_q;
  assign base_prog  = prog_q && !new_ref;
  assign acc_base   = (new_ref || open_close) ? '0 : pend_q;

  // x*10 + d as two shifted adds, saturating
  assign acc = (ACC_W'(acc_base) << 3) + (ACC_W'(acc_base) << 1) + ACC_W'(digit);
  assign acc_num = (|acc[ACC_W-1:NUMBER_BITS]) ? '1 : acc[NUMBER_BITS-1:0];

  // Queue work and next pending number
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.new_ref  = new_ref;
    ctrl_o.a_valid  = base_prog && (!is_digit || open_close);
    ctrl_o.a_is_ref = !is_cand || open_close;
    ctrl_o.b_valid  = !is_digit || in_i.last_char;
    ctrl_o.b_is_ref = !is_cand;
    ctrl_o.last_op  = is_cand && in_i.last_char;
    a_tok_o         = {KIND_NUMBER, pend_q};
    b_tok_o         = is_digit ? {KIND_NUMBER, acc_num}
                               : {KIND_LETTER, NUMBER_BITS'(in_i.char_code)};
    push_o          = accept && (ctrl_o.new_ref || ctrl_o.a_valid || ctrl_o.b_valid);

    pend_d   = pend_q;
    prog_d   = prog_q;
    closed_d = closed_q;
    if (accept) begin
      if (is_digit && !in_i.last_char) begin
        pend_d = acc_num;
        prog_d = 1'b1;
      end else begin
        pend_d = '0;
        prog_d = 1'b0;
      end
      closed_d = is_cand || in_i.last_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      prog_q   <= 1'b0;
      closed_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      prog_q   <= prog_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nosc_fifo.sv -----
// Short register queue between front and back end.
// Generic width and depth; no other dependencies.
`default_nettype none

module nosc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             full_o,
  output      logic             valid_o,
  output      logic [WIDTH-1:0] data_o,
  input  wire logic             pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == CNT_W'(DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop)      fill_q <= fill_q + 1'b1;
      else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nosc_back.sv -----
// Back end: stores reference tokens, holds the verdict register and compares
// candidate tokens one per cycle; a held verdict can stall. Uses nosc_pkg, nosc_if.
`default_nettype none

module nosc_back #(
  parameter int unsigned MAX_TOKENS  = nosc_pkg::MAX_TOKENS_DEF,
  parameter int unsigned NUMBER_BITS = nosc_pkg::NUMBER_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 head_valid_i,
  input  wire nosc_pkg::tok_ctrl_t  ctrl_i,
  input  wire logic [NUMBER_BITS:0] a_tok_i,
  input  wire logic [NUMBER_BITS:0] b_tok_i,
  output      logic                 pop_o,
  nosc_out_if.source                out_o
);
  import nosc_pkg::*;

  localparam int unsigned TOK_W  = NUMBER_BITS + 1;
  localparam int unsigned ADDR_W = $clog2(MAX_TOKENS);
  localparam int unsigned CNT_W  = $clog2(MAX_TOKENS + 1);

  // Reference token memory, one write and one read port
  logic [TOK_W-1:0]  ref_mem_q [MAX_TOKENS];
  logic [TOK_W-1:0]  rdata_q;

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic              decided_q, decided_d;
  logic              verdict_q, verdict_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic              out_before_q, out_before_d;
  logic              out_ovf_q, out_ovf_d;

  logic              first, do_a, op_valid, op_is_ref, op_last, clear, stall, go;
  logic [TOK_W-1:0]  op_tok;
  logic              we;
  logic [ADDR_W-1:0] waddr, rd_addr;

  // Pick the token operation of this cycle
  assign first     = (phase_q == PH_FIRST);
  assign do_a      = first && ctrl_i.a_valid;
  assign op_valid  = do_a || ctrl_i.b_valid;
  assign op_is_ref = do_a ? ctrl_i.a_is_ref : ctrl_i.b_is_ref;
  assign op_tok    = do_a ? a_tok_i : b_tok_i;
  assign op_last   = !do_a && ctrl_i.last_op;
  assign clear     = first && ctrl_i.new_ref;
  assign stall     = op_last && out_valid_q && !out_o.ready;
  assign go        = head_valid_i && !stall;

  assign out_o.valid                      = out_valid_q;
  assign out_o.candidate_before_reference = out_before_q;
  assign out_o.reference_overflow         = out_ovf_q;

  // Token store, compare and verdict
  always_comb begin
    phase_d      = phase_q;
    count_d      = count_q;
    pos_d        = pos_q;
    decided_d    = decided_q;
    verdict_d    = verdict_q;
    ovf_d        = ovf_q;
    out_before_d = out_before_q;
    out_ovf_d    = out_ovf_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    we           = 1'b0;
    waddr        = count_q[ADDR_W-1:0];
    pop_o        = 1'b0;

    if (go) begin
      if (clear) begin
        count_d   = '0;
        ovf_d     = 1'b0;
        pos_d     = '0;
        decided_d = 1'b0;
        verdict_d = 1'b0;
      end
      waddr = count_d[ADDR_W-1:0];

      if (op_valid && op_is_ref) begin
        if (count_d < CNT_W'(MAX_TOKENS)) begin
          we      = 1'b1;
          count_d = count_d + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end else if (op_valid && !decided_d) begin
        if (pos_d < count_d) begin
          pos_d = pos_d + 1'b1;
          if (op_tok != rdata_q) begin
            decided_d = 1'b1;
            verdict_d = (op_tok < rdata_q);
          end
        end else begin
          decided_d = 1'b1;
          verdict_d = 1'b0;
        end
      end

      // Candidate finished: all shared tokens equal means shorter wins
      if (op_last) begin
        out_valid_d  = 1'b1;
        out_before_d = decided_d ? verdict_d : (pos_d < count_d);
        out_ovf_d    = ovf_d;
        pos_d        = '0;
        decided_d    = 1'b0;
        verdict_d    = 1'b0;
      end

      if (do_a && ctrl_i.b_valid) begin
        phase_d = PH_SECOND;
      end else begin
        phase_d = PH_FIRST;
        pop_o   = 1'b1;
      end
    end
  end

  // Read uses the next position as its address so mem[pos_q] is ready when needed
  assign rd_addr = pos_d[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) ref_mem_q[waddr] <= op_tok;
    if (we && (waddr == rd_addr)) rdata_q <= op_tok;
    else                          rdata_q <= ref_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    out_before_q <= out_before_d;
    out_ovf_q    <= out_ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      count_q     <= '0;
      pos_q       <= '0;
      decided_q   <= 1'b0;
      verdict_q   <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      decided_q   <= decided_d;
      verdict_q   <= verdict_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/natural_order_string_compare.sv -----
// Top level of the natural-order string comparator: front end, queue, back end.
// Depends on nosc_pkg, nosc_if, nosc_front, nosc_fifo and nosc_back.
//
//   channel | dir | payload                                         | transfer
//   in_i    | in  | operation, char_code, last_char                 | valid & ready
//   out_o   | out | candidate_before_reference, reference_overflow  | valid & ready
//
// A byte is taken every cycle while the two-entry queue has room. The back end does
// one token operation per cycle unless a held verdict stalls it: a digit inside a
// number yields none, a byte that closes a pending number and brings its own token
// yields two, any other byte one. Reset clears control state only, not the token
// memory. A held verdict stalls only the back end; bytes keep entering until the
// queue fills.
`default_nettype none

module natural_order_string_compare #(
  parameter int unsigned MAX_TOKENS  = nosc_pkg::MAX_TOKENS_DEF,
  parameter int unsigned NUMBER_BITS = nosc_pkg::NUMBER_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nosc_in_if.sink    in_i,
  nosc_out_if.source out_o
);
  import nosc_pkg::*;

  localparam int unsigned TOK_W   = NUMBER_BITS + 1;
  localparam int unsigned CTRL_W  = $bits(tok_ctrl_t);
  localparam int unsigned ENTRY_W = CTRL_W + 2 * TOK_W;

  tok_ctrl_t          f_ctrl, b_ctrl;
  logic [TOK_W-1:0]   f_a_tok, f_b_tok, b_a_tok, b_b_tok;
  logic               push, full, head_valid, pop;
  logic [ENTRY_W-1:0] head_entry;

  nosc_front #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .ctrl_o  (f_ctrl),
    .a_tok_o (f_a_tok),
    .b_tok_o (f_b_tok)
  );

  nosc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctrl, f_a_tok, f_b_tok}),
    .full_o  (full),
    .valid_o (head_valid),
    .data_o  (head_entry),
    .pop_i   (pop)
  );

  assign b_ctrl  = tok_ctrl_t'(head_entry[ENTRY_W-1 -: CTRL_W]);
  assign b_a_tok = head_entry[2*TOK_W-1 -: TOK_W];
  assign b_b_tok = head_entry[TOK_W-1:0];

  nosc_back #(
    .MAX_TOKENS  (MAX_TOKENS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .ctrl_i       (b_ctrl),
    .a_tok_i      (b_a_tok),
    .b_tok_i      (b_b_tok),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ----- test/tb_natural_order_string_compare.sv -----
// Self-checking testbench of the natural-order string comparator: random bursty byte
// stream in, stalled verdict stream out, each verdict checked against a token predictor.
// Depends on nosc_pkg, nosc_if and natural_order_string_compare.
`default_nettype none

module tb_natural_order_string_compare;
  import nosc_pkg::*;

  localparam int unsigned NB = NUMBER_BITS_DEF;
  localparam int unsigned DEPTH = MAX_TOKENS_DEF;
  localparam longint unsigned NUM_MAX = (64'd1 << NB) - 64'd1;
  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [CHAR_W-1:0] LETTER_A = 8'h61;

  typedef logic [NB:0] token_t;
  typedef logic [CHAR_W-1:0] text_t[$];
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;
  typedef struct packed {
    logic ahead;
    logic overflow;
  } verdict_t;
  typedef enum int unsigned {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BLOCKS} sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nosc_in_if  in_if();
  nosc_out_if out_if();

  natural_order_string_compare dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: stored reference tokens and the candidate in flight
  token_t          stored_tok [DEPTH];
  int unsigned     stored_cnt = 0;
  int unsigned     cand_pos = 0;
  longint unsigned digits_val = 0;
  bit              in_number = 1'b0;
  bit              settled = 1'b0;
  bit              settled_before = 1'b0;
  bit              too_long = 1'b0;
  bit              ref_done = 1'b0;

  verdict_t    verdicts_due[$];
  char_item_t  bytes_to_send[$];
  char_item_t  next_char;
  int unsigned errors = 0;
  int unsigned items_queued = 0;

  // Decimal accumulation, saturating at the top of the number range
  function automatic void push_digit(int unsigned d);
    if (digits_val > (NUM_MAX - d) / 10) begin
      digits_val = NUM_MAX;
    end else begin
      digits_val = digits_val * 10 + d;
    end
    in_number = 1'b1;
  endfunction

  function automatic token_t number_token();
    return {KIND_NUMBER, digits_val[NB-1:0]};
  endfunction

  // Reference tokens past capacity are dropped and flagged
  function automatic void store_token(token_t tok);
    if (stored_cnt < DEPTH) begin
      stored_tok[stored_cnt] = tok;
      stored_cnt++;
    end else begin
      too_long = 1'b1;
    end
  endfunction

  // First differing token decides; running past the reference means "not before"
  function automatic void match_token(token_t tok);
    if (settled) return;
    if (cand_pos < stored_cnt) begin
      if (tok != stored_tok[cand_pos]) begin
        settled = 1'b1;
        settled_before = tok < stored_tok[cand_pos];
      end
      cand_pos++;
    end else begin
      settled = 1'b1;
      settled_before = 1'b0;
    end
  endfunction

  function automatic void clear_candidate();
    cand_pos = 0;
    digits_val = 0;
    in_number = 1'b0;
    settled = 1'b0;
    settled_before = 1'b0;
  endfunction

  function automatic void close_reference();
    if (in_number) store_token(number_token());
    digits_val = 0;
    in_number = 1'b0;
    ref_done = 1'b1;
  endfunction

  // Advance the predictor by one transferred byte; queue a verdict at a candidate's end
  function automatic void compare_byte(char_item_t it);
    bit     digit;
    token_t letter;
    digit = (it.code >= ASCII_ZERO) && (it.code <= ASCII_NINE);
    letter = {KIND_LETTER, {(NB - CHAR_W){1'b0}}, it.code};
    if (it.op == OP_REF) begin
      // a reference byte after a closed reference starts afresh
      if (ref_done) begin
        stored_cnt = 0;
        too_long = 1'b0;
        ref_done = 1'b0;
        clear_candidate();
      end
      if (digit) begin
        push_digit(int'(it.code - ASCII_ZERO));
      end else begin
        if (in_number) store_token(number_token());
        digits_val = 0;
        in_number = 1'b0;
        store_token(letter);
      end
      if (it.last) close_reference();
    end else begin
      if (!ref_done) close_reference();
      if (digit) begin
        push_digit(int'(it.code - ASCII_ZERO));
      end else begin
        if (in_number) match_token(number_token());
        digits_val = 0;
        in_number = 1'b0;
        match_token(letter);
      end
      if (it.last) begin
        if (in_number) match_token(number_token());
        // all shared tokens equal: shorter candidate sorts first
        if (!settled) settled_before = cand_pos < stored_cnt;
        verdicts_due.insert(verdicts_due.size(), '{ahead: settled_before, overflow: too_long});
        clear_candidate();
      end
    end
  endfunction

  function automatic void check_verdict();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      $error("verdict with none pending: candidate_before_reference=%0b reference_overflow=%0b",
             out_if.candidate_before_reference, out_if.reference_overflow);
      errors++;
    end else begin
      want = verdicts_due.pop_front();
      if (out_if.candidate_before_reference !== want.ahead) begin
        $error("candidate_before_reference: expected %0b, got %0b", want.ahead,
               out_if.candidate_before_reference);
        errors++;
      end
      if (out_if.reference_overflow !== want.overflow) begin
        $error("reference_overflow: expected %0b, got %0b", want.overflow,
               out_if.reference_overflow);
        errors++;
      end
    end
  endfunction

  // Stimulus construction
  function automatic void send_char(op_e op, logic [CHAR_W-1:0] code, bit last);
    bytes_to_send.insert(bytes_to_send.size(), '{op: op, code: code, last: last});
    items_queued++;
  endfunction

  function automatic void queue_text(op_e op, text_t txt, bit close);
    foreach (txt[i]) send_char(op, txt[i], close && (i == txt.size() - 1));
  endfunction

  // Mostly digits and a small alphabet so that tokens often tie
  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ASCII_ZERO + 8'($urandom_range(0, 9));
      4, 5, 6, 7: return LETTER_A + 8'($urandom_range(0, 2));
      8: return 8'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'hFF;
          2: return ASCII_ZERO - 8'd1;
          default: return ASCII_NINE + 8'd1;
        endcase
      end
    endcase
  endfunction

  // Some digit runs are long enough to saturate
  function automatic text_t random_text(int unsigned n_tok);
    text_t       t;
    int unsigned run;
    for (int unsigned k = 0; k < n_tok; k++) begin
      if ($urandom_range(0, 2) == 0) begin
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
        repeat (run) t.insert(t.size(), ASCII_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        t.insert(t.size(), pick_char());
      end
    end
    return t;
  endfunction

  // Candidate close to the reference, so that comparison runs deep
  function automatic text_t mutate(text_t src);
    text_t       t;
    text_t       extra;
    int unsigned p;
    t = src;
    p = $urandom_range(0, t.size() - 1);
    case ($urandom_range(0, 7))
      0, 1: ;
      2: while (t.size() > p + 1) void'(t.pop_back());
      3: begin
        extra = random_text($urandom_range(1, 3));
        foreach (extra[i]) t.insert(t.size(), extra[i]);
      end
      4: t[p] = pick_char();
      5: t[p] = t[p] + (($urandom_range(0, 1) != 0) ? 8'd1 : 8'd255);
      6: t.insert(p, ASCII_ZERO);
      default: t = random_text($urandom_range(1, 6));
    endcase
    return t;
  endfunction

  // Sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          in_taken = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (bytes_to_send.size() != 0) begin
        next_char = bytes_to_send.pop_front();
        in_if.valid <= 1'b1;
        in_if.operation <= next_char.op;
        in_if.char_code <= next_char.code;
        in_if.last_char <= next_char.last;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between modes every so often
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned tick = 0;

  always @(negedge clk_i) begin
    tick <= tick + 1;
    if (mode_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN: out_if.ready <= 1'b1;
      SINK_COIN: out_if.ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: out_if.ready <= (tick % 4) == 0;
      default: begin
        if (hold_left != 0) begin
          out_if.ready <= 1'b0;
          hold_left <= hold_left - 1;
        end else begin
          out_if.ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) hold_left <= $urandom_range(3, 10);
        end
      end
    endcase
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        compare_byte('{op: op_e'(in_if.operation), code: in_if.char_code,
                       last: in_if.last_char});
      end
      if (out_if.valid && out_if.ready) check_verdict();
    end
  end

  initial begin
    int unsigned long_at;
    bit          long_done;
    bit          ref_open;
    text_t       ref_text;
    text_t       base;

    in_if.valid = 1'b0;
    in_if.operation = OP_REF;
    in_if.char_code = '0;
    in_if.last_char = 1'b0;
    out_if.ready = 1'b0;

    // Directed: candidate with no reference yet
    send_char(OP_CAND, "a", 1'b1);
    // reference "b10", number closed by the last byte
    send_char(OP_REF, "b", 1'b0);
    send_char(OP_REF, "1", 1'b0);
    send_char(OP_REF, "0", 1'b1);
    // smaller number
    send_char(OP_CAND, "b", 1'b0);
    send_char(OP_CAND, "9", 1'b1);
    // leading zero, equal
    send_char(OP_CAND, "b", 1'b0);
    send_char(OP_CAND, "0", 1'b0);
    send_char(OP_CAND, "1", 1'b0);
    send_char(OP_CAND, "0", 1'b1);
    // number sorts before letter
    send_char(OP_CAND, "0", 1'b1);
    // top byte code
    send_char(OP_CAND, 8'hFF, 1'b1);
    // shorter candidate
    send_char(OP_CAND, "b", 1'b1);
    // longer candidate, number ended by a letter
    send_char(OP_CAND, "b", 1'b0);
    send_char(OP_CAND, "1", 1'b0);
    send_char(OP_CAND, "0", 1'b0);
    send_char(OP_CAND, "c", 1'b1);
    // new reference left open, closed by the candidate
    send_char(OP_REF, 8'h00, 1'b0);
    send_char(OP_CAND, 8'h00, 1'b1);

    // Random: reference then candidates near it; one reference beyond capacity
    long_at = $urandom_range(300, 900);
    long_done = 1'b0;
    while (items_queued < ITEM_TARGET) begin
      ref_text.delete();
      if (!long_done && items_queued >= long_at) begin
        repeat (DEPTH + $urandom_range(1, 8)) begin
          ref_text.insert(ref_text.size(), LETTER_A + 8'($urandom_range(0, 2)));
        end
        long_done = 1'b1;
      end else begin
        ref_text = random_text($urandom_range(1, 8));
      end
      ref_open = $urandom_range(0, 7) == 0;
      queue_text(OP_REF, ref_text, !ref_open);
      base = ref_text;
      while (base.size() > 40) void'(base.pop_back());
      repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6)) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_text(OP_CAND, random_text($urandom_range(1, 6)), 1'b1);
        end else begin
          queue_text(OP_CAND, mutate(base), 1'b1);
        end
      end
      // abandoned candidate, cut short by the next reference
      if ($urandom_range(0, 9) == 0) queue_text(OP_CAND, random_text($urandom_range(1, 3)), 1'b0);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_to_send.size() != 0 || in_if.valid) @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("natural_order_string_compare: match");
    end else begin
      $display("natural_order_string_compare: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $error("run did not complete in time");
    $display("natural_order_string_compare: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ----- natural_order_string_compare.f -----
rtl/core/nosc_pkg.sv
rtl/core/nosc_if.sv
rtl/core/nosc_front.sv
rtl/core/nosc_fifo.sv
rtl/core/nosc_back.sv
rtl/core/natural_order_string_compare.sv
test/tb_natural_order_string_compare.sv
